// ===== rtl/irbhd_pkg.sv =====
// ----------------------------------------------------------------------------
// irbhd_pkg
// Shared types, codes and helpers for the IR beam hit detector.
// ----------------------------------------------------------------------------
package irbhd_pkg;

    // Width of the millisecond timers
    localparam int TIME_BITS = 16;
    // Stuck limit register width
    localparam int STUCK_BITS = 16;
    // Compare width for timer against stuck limit
    localparam int CMP_BITS = (TIME_BITS > STUCK_BITS) ? TIME_BITS : STUCK_BITS;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0] START_SINCE_CHANGE = TIME_BITS'(20);
    localparam logic [TIME_BITS-1:0] START_SINCE_HIT = TIME_BITS'(100);

    // Input function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_TEST  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OFF   = 2'd0;
    localparam logic [1:0] STATUS_OKAY  = 2'd1;
    localparam logic [1:0] STATUS_TEST  = 2'd2;
    localparam logic [1:0] STATUS_ERROR = 2'd3;

    // Fail codes
    localparam logic [2:0] FAIL_NONE   = 3'd0;
    localparam logic [2:0] FAIL_DARK   = 3'd1;
    localparam logic [2:0] FAIL_LIGHT  = 3'd2;
    localparam logic [2:0] FAIL_SETTLE = 3'd3;
    localparam logic [2:0] FAIL_STUCK  = 3'd4;

    // Self-test sequencer steps
    localparam logic [2:0] STEP_IDLE    = 3'd0;
    localparam logic [2:0] STEP_SUPPRESS = 3'd1;
    localparam logic [2:0] STEP_EMIT_OFF = 3'd2;
    localparam logic [2:0] STEP_CHK_DARK = 3'd3;
    localparam logic [2:0] STEP_CHK_LIT  = 3'd4;
    localparam logic [2:0] STEP_CHK_HOLD = 3'd5;
    localparam logic [2:0] STEP_ERR      = 3'd6;
    localparam logic [2:0] STEP_DONE     = 3'd7;

    // Self-test wait times in ticks
    localparam logic [5:0] WAIT_SUPPRESS = 6'd10;
    localparam logic [5:0] WAIT_EMIT     = 6'd2;
    localparam logic [5:0] WAIT_HOLD     = 6'd25;
    localparam logic [5:0] WAIT_FINISH   = 6'd50;

    // Configuration register indexes
    localparam logic [1:0] REG_ENABLE     = 2'd0;
    localparam logic [1:0] REG_UNBROKEN   = 2'd1;
    localparam logic [1:0] REG_HOLDOFF    = 2'd2;
    localparam logic [1:0] REG_STUCK      = 2'd3;

    typedef struct packed {
        logic                 enable;
        logic [9:0]           unbroken_min_ms;
        logic [9:0]           hit_holdoff_ms;
        logic [STUCK_BITS-1:0] stuck_limit_ms;
    } cfg_t;

    typedef struct packed {
        logic                 started;
        logic                 last_level;
        logic [TIME_BITS-1:0] since_change;
        logic [TIME_BITS-1:0] since_hit;
        logic [31:0]          hits;
        logic                 in_error;
        logic                 ignore_hits;
        logic [2:0]           test_step;
        logic [5:0]           test_wait;
        logic [2:0]           fail_code;
        logic                 emitter;
    } state_t;

    // Saturating millisecond increment
    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
        sat_inc = (v == TIME_MAX) ? TIME_MAX : v + TIME_BITS'(1);
    endfunction

endpackage

// ===== rtl/irbhd_step.sv =====
// ----------------------------------------------------------------------------
// irbhd_step
// Next-state logic for one word: tick handling, test and clear commands, hit
// qualification, stuck check and the self-test sequencer.
// ----------------------------------------------------------------------------
module irbhd_step (
    input  irbhd_pkg::cfg_t   cfg,
    input  irbhd_pkg::state_t cur,
    input  logic [1:0]        func,
    input  logic              detector_level,
    output irbhd_pkg::state_t nxt,
    output logic              hit
);

    logic [irbhd_pkg::TIME_BITS-1:0] sc_inc;
    logic [irbhd_pkg::TIME_BITS-1:0] sh_inc;
    logic                            hit_ok;
    logic                            stuck;

    assign sc_inc = irbhd_pkg::sat_inc(cur.since_change);
    assign sh_inc = irbhd_pkg::sat_inc(cur.since_hit);

    // Break qualifies as a hit
    assign hit_ok = !cur.ignore_hits && !cur.in_error && detector_level
                  && (sc_inc >= irbhd_pkg::TIME_BITS'(cfg.unbroken_min_ms))
                  && (sh_inc >= irbhd_pkg::TIME_BITS'(cfg.hit_holdoff_ms));

    // Beam broken past the limit; on a level change the timer restarts at zero
    assign stuck = (detector_level == cur.last_level) && detector_level
                 && (irbhd_pkg::CMP_BITS'(sc_inc)
                     > irbhd_pkg::CMP_BITS'(cfg.stuck_limit_ms));

    always_comb
    begin
        nxt = cur;
        hit = 1'b0;
        case (func)
            irbhd_pkg::FUNC_TICK:
            begin
                if (!cur.started)
                begin
                    // Start tick: power the emitter and arm the self test
                    if (cfg.enable)
                    begin
                        nxt.started      = 1'b1;
                        nxt.emitter      = 1'b1;
                        nxt.since_change = irbhd_pkg::START_SINCE_CHANGE;
                        nxt.since_hit    = irbhd_pkg::START_SINCE_HIT;
                        nxt.test_step    = irbhd_pkg::STEP_SUPPRESS;
                        nxt.test_wait    = '0;
                    end
                end
                else
                begin
                    nxt.since_change = sc_inc;
                    nxt.since_hit    = sh_inc;
                    // Level change handling
                    if (detector_level != cur.last_level)
                    begin
                        nxt.since_change = '0;
                        nxt.last_level   = detector_level;
                        if (hit_ok)
                        begin
                            nxt.hits      = cur.hits + 32'd1;
                            nxt.since_hit = '0;
                            hit           = 1'b1;
                        end
                    end
                    // Self-test sequencer or stuck check
                    if (cur.test_step != irbhd_pkg::STEP_IDLE)
                    begin
                        if (cur.test_wait > 6'd1)
                        begin
                            nxt.test_wait = cur.test_wait - 6'd1;
                        end
                        else
                        begin
                            nxt.test_wait = '0;
                            unique case (cur.test_step)
                                irbhd_pkg::STEP_SUPPRESS:
                                begin
                                    nxt.ignore_hits = 1'b1;
                                    nxt.test_wait   = irbhd_pkg::WAIT_SUPPRESS;
                                    nxt.test_step   = irbhd_pkg::STEP_EMIT_OFF;
                                end
                                irbhd_pkg::STEP_EMIT_OFF:
                                begin
                                    nxt.emitter   = 1'b0;
                                    nxt.test_wait = irbhd_pkg::WAIT_EMIT;
                                    nxt.test_step = irbhd_pkg::STEP_CHK_DARK;
                                end
                                irbhd_pkg::STEP_CHK_DARK:
                                begin
                                    if (!detector_level)
                                    begin
                                        nxt.test_step = irbhd_pkg::STEP_ERR;
                                        nxt.fail_code = irbhd_pkg::FAIL_DARK;
                                    end
                                    else
                                    begin
                                        nxt.emitter   = 1'b1;
                                        nxt.test_wait = irbhd_pkg::WAIT_EMIT;
                                        nxt.test_step = irbhd_pkg::STEP_CHK_LIT;
                                    end
                                end
                                irbhd_pkg::STEP_CHK_LIT:
                                begin
                                    if (detector_level)
                                    begin
                                        nxt.test_step = irbhd_pkg::STEP_ERR;
                                        nxt.fail_code = irbhd_pkg::FAIL_LIGHT;
                                    end
                                    else
                                    begin
                                        nxt.test_wait = irbhd_pkg::WAIT_HOLD;
                                        nxt.test_step = irbhd_pkg::STEP_CHK_HOLD;
                                    end
                                end
                                irbhd_pkg::STEP_CHK_HOLD:
                                begin
                                    if (detector_level)
                                    begin
                                        nxt.test_step = irbhd_pkg::STEP_ERR;
                                        nxt.fail_code = irbhd_pkg::FAIL_SETTLE;
                                    end
                                    else
                                    begin
                                        nxt.in_error  = 1'b0;
                                        nxt.emitter   = 1'b1;
                                        nxt.test_wait = irbhd_pkg::WAIT_FINISH;
                                        nxt.test_step = irbhd_pkg::STEP_DONE;
                                        nxt.fail_code = irbhd_pkg::FAIL_NONE;
                                    end
                                end
                                irbhd_pkg::STEP_ERR:
                                begin
                                    nxt.in_error  = 1'b1;
                                    nxt.emitter   = 1'b1;
                                    nxt.test_wait = irbhd_pkg::WAIT_FINISH;
                                    nxt.test_step = irbhd_pkg::STEP_DONE;
                                end
                                default:
                                begin
                                    // Finish: release suppression, keep fail code
                                    nxt.test_step   = irbhd_pkg::STEP_IDLE;
                                    nxt.ignore_hits = 1'b0;
                                end
                            endcase
                        end
                    end
                    else if (!cur.in_error && stuck)
                    begin
                        nxt.in_error  = 1'b1;
                        nxt.fail_code = irbhd_pkg::FAIL_STUCK;
                    end
                end
            end
            irbhd_pkg::FUNC_TEST:
            begin
                if (cur.started && (cur.test_step == irbhd_pkg::STEP_IDLE))
                begin
                    nxt.test_step = irbhd_pkg::STEP_SUPPRESS;
                    nxt.test_wait = '0;
                end
            end
            irbhd_pkg::FUNC_CLEAR:
            begin
                nxt.hits = '0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ===== rtl/ir_beam_hit_detector_core.sv =====
// ----------------------------------------------------------------------------
// ir_beam_hit_detector_core
// IR beam hit detector: hit counting, stuck-beam error and emitter self test.
// ----------------------------------------------------------------------------
// One input word (tick or command) is accepted per clock cycle unless in_stall
// is high. Its result appears in the output register on the next cycle. The
// only back-pressure path is the result register: in_stall is high while that
// register holds a word and out_stall is high. Detector state, counters and
// the self-test sequencer all update in the same cycle the word is accepted.
// Configuration writes take effect on the next clock edge and should be made
// while idle.
module ir_beam_hit_detector_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic        detector_level,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hit_count,
    output logic        hit_now,
    output logic [1:0]  status,
    output logic [2:0]  fail_code,
    output logic        emitter_on
);

    irbhd_pkg::cfg_t   cfg_reg;
    irbhd_pkg::state_t state_reg;
    irbhd_pkg::state_t state_next;
    logic              hit_next;
    logic [1:0]        status_next;
    logic              in_acc;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [31:0]       hit_count_reg;
    logic              hit_now_reg;
    logic [1:0]        status_reg;
    logic [2:0]        fail_code_reg;
    logic              emitter_on_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable          <= 1'b0;
            cfg_reg.unbroken_min_ms <= 10'd50;
            cfg_reg.hit_holdoff_ms  <= 10'd100;
            cfg_reg.stuck_limit_ms  <= 16'd1500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                irbhd_pkg::REG_ENABLE:   cfg_reg.enable          <= cfg_data[0];
                irbhd_pkg::REG_UNBROKEN: cfg_reg.unbroken_min_ms <= cfg_data[9:0];
                irbhd_pkg::REG_HOLDOFF:  cfg_reg.hit_holdoff_ms  <= cfg_data[9:0];
                irbhd_pkg::REG_STUCK:    cfg_reg.stuck_limit_ms  <= cfg_data[15:0];
                default:                 cfg_reg.enable          <= cfg_reg.enable;
            endcase
        end
    end

    // Handshake
    assign in_stall       = out_valid_reg && out_stall;
    assign in_acc         = in_valid && !in_stall;
    assign out_valid_next = in_acc || (out_valid_reg && out_stall);

    // Next-state logic
    irbhd_step u_step (
        .cfg            (cfg_reg),
        .cur            (state_reg),
        .func           (func),
        .detector_level (detector_level),
        .nxt            (state_next),
        .hit            (hit_next)
    );

    // Status from the updated state
    always_comb
    begin
        if (!state_next.started)
            status_next = irbhd_pkg::STATUS_OFF;
        else if (state_next.test_step != irbhd_pkg::STEP_IDLE)
            status_next = irbhd_pkg::STATUS_TEST;
        else if (state_next.in_error)
            status_next = irbhd_pkg::STATUS_ERROR;
        else
            status_next = irbhd_pkg::STATUS_OKAY;
    end

    // Detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.started      <= 1'b0;
            state_reg.last_level   <= 1'b0;
            state_reg.since_change <= irbhd_pkg::START_SINCE_CHANGE;
            state_reg.since_hit    <= irbhd_pkg::START_SINCE_HIT;
            state_reg.hits         <= '0;
            state_reg.in_error     <= 1'b0;
            state_reg.ignore_hits  <= 1'b0;
            state_reg.test_step    <= irbhd_pkg::STEP_IDLE;
            state_reg.test_wait    <= '0;
            state_reg.fail_code    <= irbhd_pkg::FAIL_NONE;
            state_reg.emitter      <= 1'b0;
        end
        else if (in_acc)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            hit_count_reg  <= state_next.hits;
            hit_now_reg    <= hit_next;
            status_reg     <= status_next;
            fail_code_reg  <= state_next.fail_code;
            emitter_on_reg <= state_next.emitter;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit_count  = hit_count_reg;
    assign hit_now    = hit_now_reg;
    assign status     = status_reg;
    assign fail_code  = fail_code_reg;
    assign emitter_on = emitter_on_reg;

`ifndef SYNTHESIS
    // Back-pressure only arises from a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with empty result register");

    // Every accepted word produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid_reg)
        else $error("accepted word produced no result");

    // An idle sequencer carries no pending wait
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.test_step == irbhd_pkg::STEP_IDLE) |-> (state_reg.test_wait == 6'd0))
        else $error("test wait pending while sequencer idle");

    // Once started the block stays started
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.started |=> state_reg.started)
        else $error("started flag dropped");
`endif

endmodule

// ===== tb/tb_ir_beam_hit_detector_core.sv =====
// ----------------------------------------------------------------------------
// tb_ir_beam_hit_detector_core
// Self-checking bench for the IR beam hit detector core. A built-in
// predictor tracks timers, hit counting, stuck-beam error and the emitter
// self test. It produces one expected word per accepted input word.
// Stimulus comes in three parts: a directed table, then random beam traffic
// under three idle patterns, then a complete self test at the widest
// settings followed by a short break of the beam.
// ----------------------------------------------------------------------------
module tb_ir_beam_hit_detector_core;

    timeunit 1ns;
    timeprecision 1ps;

    // Unused function code, must be ignored by the block
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] hit_count;
        logic        hit_now;
        logic [1:0]  status;
        logic [2:0]  fail_code;
        logic        emitter_on;
    } beam_result_t;

    // Directed table row: either an input word or a register write
    localparam logic ROW_WORD = 1'b0;
    localparam logic ROW_REG  = 1'b1;

    typedef struct packed {
        logic         kind;
        logic [1:0]   idx;
        logic [15:0]  data;
        logic [1:0]   func;
        logic         level;
        logic         typed;
        beam_result_t res;
    } plan_row_t;

    localparam beam_result_t NO_RES    = '0;
    localparam beam_result_t OFF_RES   = '{32'd0, 1'b0, irbhd_pkg::STATUS_OFF,
                                           irbhd_pkg::FAIL_NONE, 1'b0};
    localparam beam_result_t START_RES = '{32'd0, 1'b0, irbhd_pkg::STATUS_TEST,
                                           irbhd_pkg::FAIL_NONE, 1'b1};

    localparam int PLAN_LEN = 26;

    // Pre-start words, start tick, hit during step one, then a self test
    // that fails its dark check and enters the error step.
    localparam plan_row_t DIR_PLAN [PLAN_LEN] = '{
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b0, 1'b1, OFF_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b1, 1'b1, OFF_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TEST, 1'b0, 1'b1, OFF_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_CLEAR, 1'b1, 1'b1, OFF_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, FUNC_UNUSED, 1'b1, 1'b1, OFF_RES},
        '{ROW_REG, irbhd_pkg::REG_ENABLE, 16'd1, irbhd_pkg::FUNC_TICK, 1'b0, 1'b0, NO_RES},
        '{ROW_REG, irbhd_pkg::REG_UNBROKEN, 16'd0, irbhd_pkg::FUNC_TICK, 1'b0, 1'b0, NO_RES},
        '{ROW_REG, irbhd_pkg::REG_HOLDOFF, 16'd0, irbhd_pkg::FUNC_TICK, 1'b0, 1'b0, NO_RES},
        '{ROW_REG, irbhd_pkg::REG_STUCK, 16'd1, irbhd_pkg::FUNC_TICK, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b0, 1'b1, START_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TEST, 1'b0, 1'b1, START_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b1, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_CLEAR, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b1, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b1, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b1, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b1, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b1, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b1, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b0, 1'b0, NO_RES},
        '{ROW_WORD, irbhd_pkg::REG_ENABLE, 16'd0, irbhd_pkg::FUNC_TICK, 1'b0, 1'b0, NO_RES}
    };

    // DUT ports; all inputs driven to known values from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = irbhd_pkg::REG_ENABLE;
    logic [15:0] cfg_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = irbhd_pkg::FUNC_TICK;
    logic        detector_level = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] hit_count;
    logic        hit_now;
    logic [1:0]  status;
    logic [2:0]  fail_code;
    logic        emitter_on;

    // Predicted detector state
    logic                            p_started = 1'b0;
    logic                            p_last = 1'b0;
    logic [irbhd_pkg::TIME_BITS-1:0] p_since_change = irbhd_pkg::START_SINCE_CHANGE;
    logic [irbhd_pkg::TIME_BITS-1:0] p_since_hit = irbhd_pkg::START_SINCE_HIT;
    logic [31:0]                     p_hits = '0;
    logic                            p_in_error = 1'b0;
    logic                            p_ignore = 1'b0;
    logic [2:0]                      p_step = irbhd_pkg::STEP_IDLE;
    logic [5:0]                      p_wait = '0;
    logic [2:0]                      p_fail = irbhd_pkg::FAIL_NONE;
    logic                            p_emit = 1'b0;

    // Predicted register contents
    logic        c_enable = 1'b0;
    logic [9:0]  c_min = 10'd50;
    logic [9:0]  c_holdoff = 10'd100;
    logic [15:0] c_stuck = 16'd1500;

    beam_result_t expected_q[$];
    int           fault_cnt = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    bit           hold_req = 1'b0;
    int           hold_cnt = 0;

    // Beam model for random traffic
    logic obj_present = 1'b0;
    int   run_left = 0;

    ir_beam_hit_detector_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .detector_level (detector_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit_count      (hit_count),
        .hit_now        (hit_now),
        .status         (status),
        .fail_code      (fail_code),
        .emitter_on     (emitter_on)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the predicted state by one word and return its result
    task automatic predict_word(input logic [1:0] f, input logic lvl,
                                output beam_result_t r);
        logic                            hit;
        logic [irbhd_pkg::TIME_BITS-1:0] elapsed;
        logic [5:0]                      nxt_wait;
        hit = 1'b0;
        if (f == irbhd_pkg::FUNC_TICK)
        begin
            if (!p_started)
            begin
                // first enabled tick only starts the block and arms a test
                if (c_enable)
                begin
                    p_started = 1'b1;
                    p_emit = 1'b1;
                    p_since_change = irbhd_pkg::START_SINCE_CHANGE;
                    p_since_hit = irbhd_pkg::START_SINCE_HIT;
                    if (p_step == irbhd_pkg::STEP_IDLE)
                    begin
                        p_step = irbhd_pkg::STEP_SUPPRESS;
                        p_wait = '0;
                    end
                end
            end
            else
            begin
                if (p_since_change != irbhd_pkg::TIME_MAX)
                    p_since_change = p_since_change + 1'b1;
                if (p_since_hit != irbhd_pkg::TIME_MAX)
                    p_since_hit = p_since_hit + 1'b1;
                // edge handling; only a break may count
                if (lvl != p_last)
                begin
                    elapsed = p_since_change;
                    p_since_change = '0;
                    p_last = lvl;
                    if (!p_ignore && !p_in_error && lvl && elapsed >= c_min &&
                        p_since_hit >= c_holdoff)
                    begin
                        p_hits = p_hits + 1'b1;
                        p_since_hit = '0;
                        hit = 1'b1;
                    end
                end
                if (p_step != irbhd_pkg::STEP_IDLE)
                begin
                    // self-test sequencer
                    if (p_wait > 6'd1)
                        p_wait = p_wait - 1'b1;
                    else
                    begin
                        nxt_wait = '0;
                        case (p_step)
                            irbhd_pkg::STEP_SUPPRESS:
                            begin
                                p_ignore = 1'b1;
                                nxt_wait = irbhd_pkg::WAIT_SUPPRESS;
                                p_step = irbhd_pkg::STEP_EMIT_OFF;
                            end
                            irbhd_pkg::STEP_EMIT_OFF:
                            begin
                                p_emit = 1'b0;
                                nxt_wait = irbhd_pkg::WAIT_EMIT;
                                p_step = irbhd_pkg::STEP_CHK_DARK;
                            end
                            irbhd_pkg::STEP_CHK_DARK:
                            begin
                                if (!lvl)
                                begin
                                    p_step = irbhd_pkg::STEP_ERR;
                                    p_fail = irbhd_pkg::FAIL_DARK;
                                end
                                else
                                begin
                                    p_emit = 1'b1;
                                    nxt_wait = irbhd_pkg::WAIT_EMIT;
                                    p_step = irbhd_pkg::STEP_CHK_LIT;
                                end
                            end
                            irbhd_pkg::STEP_CHK_LIT:
                            begin
                                if (lvl)
                                begin
                                    p_step = irbhd_pkg::STEP_ERR;
                                    p_fail = irbhd_pkg::FAIL_LIGHT;
                                end
                                else
                                begin
                                    nxt_wait = irbhd_pkg::WAIT_HOLD;
                                    p_step = irbhd_pkg::STEP_CHK_HOLD;
                                end
                            end
                            irbhd_pkg::STEP_CHK_HOLD:
                            begin
                                if (lvl)
                                begin
                                    p_step = irbhd_pkg::STEP_ERR;
                                    p_fail = irbhd_pkg::FAIL_SETTLE;
                                end
                                else
                                begin
                                    p_in_error = 1'b0;
                                    p_emit = 1'b1;
                                    nxt_wait = irbhd_pkg::WAIT_FINISH;
                                    p_step = irbhd_pkg::STEP_DONE;
                                    p_fail = irbhd_pkg::FAIL_NONE;
                                end
                            end
                            irbhd_pkg::STEP_ERR:
                            begin
                                p_in_error = 1'b1;
                                p_emit = 1'b1;
                                nxt_wait = irbhd_pkg::WAIT_FINISH;
                                p_step = irbhd_pkg::STEP_DONE;
                            end
                            default:
                            begin
                                p_step = irbhd_pkg::STEP_IDLE;
                                p_ignore = 1'b0;
                            end
                        endcase
                        p_wait = nxt_wait;
                    end
                end
                else if (!p_in_error && p_last && p_since_change > c_stuck)
                begin
                    p_in_error = 1'b1;
                    p_fail = irbhd_pkg::FAIL_STUCK;
                end
            end
        end
        else if (f == irbhd_pkg::FUNC_TEST)
        begin
            if (p_started && p_step == irbhd_pkg::STEP_IDLE)
            begin
                p_step = irbhd_pkg::STEP_SUPPRESS;
                p_wait = '0;
            end
        end
        else if (f == irbhd_pkg::FUNC_CLEAR)
            p_hits = '0;

        r.hit_count = p_hits;
        r.hit_now = hit;
        if (!p_started) r.status = irbhd_pkg::STATUS_OFF;
        else if (p_step != irbhd_pkg::STEP_IDLE) r.status = irbhd_pkg::STATUS_TEST;
        else if (p_in_error) r.status = irbhd_pkg::STATUS_ERROR;
        else r.status = irbhd_pkg::STATUS_OKAY;
        r.fail_code = p_fail;
        r.emitter_on = p_emit;
    endtask

    // Offer one word, wait for its acceptance, queue its expectation
    task automatic send_word(input logic [1:0] f, input logic lvl,
                             input logic typed, input beam_result_t typed_res);
        beam_result_t r;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        detector_level <= lvl;
        do @(posedge clk); while (in_stall);
        predict_word(f, lvl, r);
        expected_q.push_back(typed ? typed_res : r);
    endtask

    // Stop offering and wait until every expected word has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        case (idx)
            irbhd_pkg::REG_ENABLE:   c_enable = d[0];
            irbhd_pkg::REG_UNBROKEN: c_min = d[9:0];
            irbhd_pkg::REG_HOLDOFF:  c_holdoff = d[9:0];
            default:                 c_stuck = d;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic en, input int mn, input int hold, input int stk);
        drain();
        write_reg(irbhd_pkg::REG_ENABLE, 16'(en));
        write_reg(irbhd_pkg::REG_UNBROKEN, 16'(mn));
        write_reg(irbhd_pkg::REG_HOLDOFF, 16'(hold));
        write_reg(irbhd_pkg::REG_STUCK, 16'(stk));
    endtask

    // Random word: mostly ticks from a beam that objects cross, seen
    // through the emitter, with a little noise and some commands
    task automatic next_item(output logic [1:0] f, output logic lvl);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 2) f = irbhd_pkg::FUNC_TEST;
        else if (pick < 4) f = irbhd_pkg::FUNC_CLEAR;
        else if (pick == 4) f = FUNC_UNUSED;
        else f = irbhd_pkg::FUNC_TICK;
        if (f == irbhd_pkg::FUNC_TICK)
        begin
            if (run_left == 0)
            begin
                obj_present = !obj_present;
                if (obj_present)
                    run_left = ($urandom_range(7) == 0) ? int'(c_stuck) + $urandom_range(1, 8)
                                                        : $urandom_range(1, 6);
                else
                    run_left = $urandom_range(1, 2 * int'(c_min) + int'(c_holdoff) / 2 + 4);
            end
            run_left--;
        end
        lvl = obj_present | !p_emit;
        if ($urandom_range(99) < 3) lvl = !lvl;
    endtask

    task automatic run_phase(input int tx, input int rx, input int n, input logic en,
                             input int mn, input int hold, input int stk);
        logic [1:0] f;
        logic       lvl;
        set_config(en, mn, hold, stk);
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        for (int i = 0; i < n; i++)
        begin
            // long output hold-off, later a pause until the pipe is empty
            if (i == 120) hold_req = 1'b1;
            if (i == 250) drain();
            next_item(f, lvl);
            send_word(f, lvl, 1'b0, NO_RES);
        end
    endtask

    // Receiver side: random stall, or a long counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = 60;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
    end

    // Compare each delivered word with the oldest expectation
    always @(posedge clk)
    begin
        beam_result_t got;
        beam_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{hit_count, hit_now, status, fail_code, emitter_on};
            if (expected_q.size() == 0)
            begin
                fault_cnt++;
                if (fault_cnt <= 10)
                    $display("unexpected word: cnt=%0d hit=%0b st=%0d fail=%0d emit=%0b",
                             got.hit_count, got.hit_now, got.status, got.fail_code,
                             got.emitter_on);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.hit_count !== want.hit_count || got.hit_now !== want.hit_now ||
                    got.status !== want.status || got.fail_code !== want.fail_code ||
                    got.emitter_on !== want.emitter_on)
                begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                    begin
                        $display("mismatch @%0t: exp cnt=%0d hit=%0b st=%0d fail=%0d emit=%0b",
                                 $time, want.hit_count, want.hit_now, want.status,
                                 want.fail_code, want.emitter_on);
                        $display("    got cnt=%0d hit=%0b st=%0d fail=%0d emit=%0b",
                                 got.hit_count, got.hit_now, got.status, got.fail_code,
                                 got.emitter_on);
                    end
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (DIR_PLAN[i].kind == ROW_REG)
            begin
                drain();
                write_reg(DIR_PLAN[i].idx, DIR_PLAN[i].data);
            end
            else
                send_word(DIR_PLAN[i].func, DIR_PLAN[i].level, DIR_PLAN[i].typed,
                          DIR_PLAN[i].res);
        end

        // random beam traffic; second phase clears enable after start
        run_phase(12, 70, 350, 1'b1, 3, 5, 30);
        run_phase(70, 12, 350, 1'b0, 1, 0, 12);
        run_phase(0, 0, 350, 1'b1, 8, 20, 60);

        // widest settings: a complete self test with the beam following the
        // emitter, then a short break and recovery
        drain();
        set_config(1'b1, 1023, 1023, 65535);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_word(irbhd_pkg::FUNC_TEST, 1'b0, 1'b0, NO_RES);
        repeat (95) send_word(irbhd_pkg::FUNC_TICK, !p_emit, 1'b0, NO_RES);
        repeat (3) send_word(irbhd_pkg::FUNC_TICK, 1'b1, 1'b0, NO_RES);
        repeat (3) send_word(irbhd_pkg::FUNC_TICK, 1'b0, 1'b0, NO_RES);
        send_word(irbhd_pkg::FUNC_CLEAR, 1'b1, 1'b0, NO_RES);

        drain();
        repeat (4) @(posedge clk);
        if (expected_q.size() != 0) fault_cnt++;
        if (fault_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
